// ===== design/dic_pkg.sv =====
package dic_pkg;

  localparam int ROW_W  = 32;
  localparam int IDX_W  = 5;
  localparam int CNT_W  = 9;
  localparam int NODE_W = 6;
  localparam int SUM_W  = 10;

  typedef struct packed {
    logic [IDX_W-1:0] row_index;
    logic [ROW_W-1:0] parent_bits;
    logic             last_row;
  } in_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] immorality_count;
    logic [ROW_W-1:0] cycle_mask;
  } out_word_t;

  // row write from the load side into the parent store
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [ROW_W-1:0] data;
  } row_wr_t;

  typedef struct packed {
    logic              start;
    logic [NODE_W-1:0] node_cnt;
  } eng_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

endpackage

// ===== design/dag_immorality_and_cycle_check_top.sv =====
// Parent-matrix checker: immorality count and cycle membership of a small DAG.
// Input channel (in_valid_i / in_stall_o / in_word_i): one word per node, the
// node's parent bit-row; rows are sent in order and the word with last_row set
// closes the graph, the node count being row_index + 1 (capped at MAX_NODES).
// Rows at or above MAX_NODES are dropped.
// Load words are taken one per cycle while in_stall_o is low. The closing word
// starts an evaluation in one shared datapath that walks the stored rows through
// two row memories; the result is written to the output register after the
// reachability closure sweep and the co-parent sweep, which each read every row
// once per node. in_stall_o stays high after the closing word until the result
// is taken into the output register.
// Output channel (out_valid_o / out_stall_i / out_word_o): one word per graph.
// While the receiver stalls, the result word is held and new rows may still be
// loaded; a following evaluation waits for the register to free up.
// Reset clears the sequencer and the output valid; stored rows are not cleared.
module dag_immorality_and_cycle_check_top #(
  parameter int MAX_NODES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dic_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dic_pkg::out_word_t out_word_o
);
  import dic_pkg::*;

  localparam int SLOTS = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
  localparam logic [NODE_W-1:0] SLOTS_N = NODE_W'(SLOTS);

  logic              in_take, res_ready;
  logic [NODE_W-1:0] idx_p1;
  row_wr_t           ld;
  eng_cmd_t          cmd;
  eng_stat_t         stat;
  out_word_t         result;
  logic              out_valid_q;
  out_word_t         out_word_q;

  assign in_take = in_valid_i && !in_stall_o;
  assign idx_p1  = {1'b0, in_word_i.row_index} + NODE_W'(1);

  assign ld.we   = in_take && (int'(in_word_i.row_index) < MAX_NODES);
  assign ld.addr = in_word_i.row_index;
  assign ld.data = in_word_i.parent_bits;

  assign cmd.start    = in_take && in_word_i.last_row;
  assign cmd.node_cnt = (idx_p1 > SLOTS_N) ? SLOTS_N : idx_p1;

  assign res_ready = !out_valid_q || !out_stall_i;

  dic_engine #(.SLOTS(SLOTS)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_i        (ld),
    .cmd_i       (cmd),
    .res_ready_i (res_ready),
    .stat_o      (stat),
    .result_o    (result)
  );

  assign in_stall_o = stat.busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.done) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // a finished evaluation never overwrites a word the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrites pending output word");

  // the closing row starts an evaluation and blocks further rows
  a_stall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && in_word_i.last_row) |=> in_stall_o)
    else $error("no stall after last row");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.immorality_count <= 9'd496))
    else $error("immorality count out of range");

  // a result only appears after an evaluation held the input side
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |-> in_stall_o)
    else $error("done without busy engine");

endmodule

// ===== design/dic_row_ram.sv =====
module dic_row_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/dic_engine.sv =====
module dic_engine #(
  parameter int SLOTS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dic_pkg::row_wr_t   ld_i,
  input  dic_pkg::eng_cmd_t  cmd_i,
  input  logic               res_ready_i,
  output dic_pkg::eng_stat_t stat_o,
  output dic_pkg::out_word_t result_o
);
  import dic_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INIT = 3'd1;
  localparam logic [2:0] ST_CLK  = 3'd2;
  localparam logic [2:0] ST_CLI  = 3'd3;
  localparam logic [2:0] ST_CYC  = 3'd4;
  localparam logic [2:0] ST_PAIR = 3'd5;
  localparam logic [2:0] ST_SUM  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  function automatic logic [ROW_W-1:0] low_mask(input logic [NODE_W-1:0] n);
    logic [ROW_W-1:0] m;
    for (int b = 0; b < ROW_W; b++) begin
      m[b] = (NODE_W'(b) < n);
    end
    return m;
  endfunction

  function automatic logic [NODE_W-1:0] ones_in(input logic [ROW_W-1:0] v);
    logic [2:0]        nib [ROW_W/4];
    logic [NODE_W-1:0] c;
    for (int q = 0; q < ROW_W / 4; q++) begin
      nib[q] = 3'(v[4*q]) + 3'(v[4*q+1]) + 3'(v[4*q+2]) + 3'(v[4*q+3]);
    end
    c = '0;
    for (int q = 0; q < ROW_W / 4; q++) begin
      c = c + NODE_W'(nib[q]);
    end
    return c;
  endfunction

  logic [2:0]        st_q, st_d;
  logic              ph_q, ph_d;
  logic [NODE_W-1:0] i_q, i_d, k_q, k_d, n_q, n_d;
  logic [ROW_W-1:0]  mask_q, mask_d;
  logic [ROW_W-1:0]  wk_q, wk_d;
  logic [ROW_W-1:0]  acc_q, acc_d;
  logic [ROW_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  rowk_q, rowk_d;
  logic [ROW_W-1:0]  cyc_q, cyc_d;
  logic [SUM_W-1:0]  tot_q, tot_d;

  logic [ROW_W-1:0]  par_rd, work_rd, work_wdata, g_row, unsat;
  logic [ROW_W-1:0]  i_hot, k_hot;
  logic [AW-1:0]     work_raddr;
  logic              work_we, done, i_last, k_last;

  dic_row_ram #(.DEPTH(SLOTS), .WIDTH(ROW_W), .AW(AW)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (ld_i.we),
    .waddr_i (ld_i.addr[AW-1:0]),
    .wdata_i (ld_i.data),
    .raddr_i (i_q[AW-1:0]),
    .rdata_o (par_rd)
  );

  dic_row_ram #(.DEPTH(SLOTS), .WIDTH(ROW_W), .AW(AW)) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (work_we),
    .waddr_i (i_q[AW-1:0]),
    .wdata_i (work_wdata),
    .raddr_i (work_raddr),
    .rdata_o (work_rd)
  );

  assign work_raddr = (st_q == ST_CLK) ? k_q[AW-1:0] : i_q[AW-1:0];
  assign i_last     = (i_q == n_q - NODE_W'(1));
  assign k_last     = (k_q == n_q - NODE_W'(1));
  assign i_hot      = ROW_W'(1) << i_q[IDX_W-1:0];
  assign k_hot      = ROW_W'(1) << k_q[IDX_W-1:0];
  assign g_row      = par_rd & mask_q;
  // co-parents of k, minus k itself and every node adjacent to k
  assign unsat      = acc_q & ~col_q & ~rowk_q & ~k_hot & mask_q;

  always_comb begin
    st_d       = st_q;
    ph_d       = ph_q;
    i_d        = i_q;
    k_d        = k_q;
    n_d        = n_q;
    mask_d     = mask_q;
    wk_d       = wk_q;
    acc_d      = acc_q;
    col_d      = col_q;
    rowk_d     = rowk_q;
    cyc_d      = cyc_q;
    tot_d      = tot_q;
    work_we    = 1'b0;
    work_wdata = work_rd;
    done       = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (cmd_i.start) begin
          st_d   = ST_INIT;
          n_d    = cmd_i.node_cnt;
          mask_d = low_mask(cmd_i.node_cnt);
          i_d    = '0;
          ph_d   = 1'b0;
          cyc_d  = '0;
          tot_d  = '0;
        end
      end
      ST_INIT: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          work_we    = 1'b1;
          work_wdata = g_row & ~i_hot;
          if (i_last) begin
            st_d = ST_CLK;
            i_d  = '0;
            k_d  = '0;
          end else begin
            i_d = i_q + NODE_W'(1);
          end
        end
      end
      ST_CLK: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          wk_d = work_rd;
          i_d  = '0;
          st_d = ST_CLI;
        end
      end
      ST_CLI: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          if (work_rd[k_q[IDX_W-1:0]]) begin
            work_we    = 1'b1;
            work_wdata = work_rd | wk_q;
          end
          if (i_last) begin
            i_d = '0;
            if (k_last) begin
              st_d = ST_CYC;
            end else begin
              k_d  = k_q + NODE_W'(1);
              st_d = ST_CLK;
            end
          end else begin
            i_d = i_q + NODE_W'(1);
          end
        end
      end
      ST_CYC: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          cyc_d[i_q[IDX_W-1:0]] = work_rd[i_q[IDX_W-1:0]];
          if (i_last) begin
            st_d   = ST_PAIR;
            i_d    = '0;
            k_d    = '0;
            acc_d  = '0;
            col_d  = '0;
            rowk_d = '0;
          end else begin
            i_d = i_q + NODE_W'(1);
          end
        end
      end
      ST_PAIR: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          if ((i_q != k_q) && g_row[k_q[IDX_W-1:0]]) begin
            acc_d = acc_q | g_row;
          end
          col_d[i_q[IDX_W-1:0]] = g_row[k_q[IDX_W-1:0]];
          if (i_q == k_q) begin
            rowk_d = g_row;
          end
          if (i_last) begin
            st_d = ST_SUM;
          end else begin
            i_d = i_q + NODE_W'(1);
          end
        end
      end
      ST_SUM: begin
        tot_d = tot_q + SUM_W'(ones_in(unsat));
        ph_d  = 1'b0;
        if (k_last) begin
          st_d = ST_FIN;
        end else begin
          k_d    = k_q + NODE_W'(1);
          i_d    = '0;
          acc_d  = '0;
          col_d  = '0;
          rowk_d = '0;
          st_d   = ST_PAIR;
        end
      end
      ST_FIN: begin
        if (res_ready_i) begin
          done = 1'b1;
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ph_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    k_q    <= k_d;
    n_q    <= n_d;
    mask_q <= mask_d;
    wk_q   <= wk_d;
    acc_q  <= acc_d;
    col_q  <= col_d;
    rowk_q <= rowk_d;
    cyc_q  <= cyc_d;
    tot_q  <= tot_d;
  end

  // every pair was seen from both ends
  assign result_o.immorality_count = tot_q[SUM_W-1:1];
  assign result_o.cycle_mask       = cyc_q;
  assign stat_o.busy               = (st_q != ST_IDLE);
  assign stat_o.done               = done;

endmodule
